// ===== rtl/delta_offset_table_decoder_macros.svh =====
// Assertion helpers for the offset table decoder.
`ifndef DELTA_OFFSET_TABLE_DECODER_MACROS_SVH
`define DELTA_OFFSET_TABLE_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DOTD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DOTD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dotd_pkg.sv =====
package dotd_pkg;

   localparam int OFFSET_BITS    = 32;
   localparam int OUT_BITS       = OFFSET_BITS + 3;
   localparam int COUNT_BITS     = 32;
   localparam int VALUE_BITS     = 30;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 32;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_SHIFT_MODE   = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TABLE_LENGTH = 1'b1;

   // lead byte tags
   localparam logic [1:0] TAG_STOP = 2'd0;
   localparam logic [1:0] TAG_ONE  = 2'd1;
   localparam logic [1:0] TAG_TWO  = 2'd2;
   localparam logic [1:0] TAG_FOUR = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_OFFSET = 2'd0;
   localparam logic [1:0] STATUS_LIMIT  = 2'd1;
   localparam logic [1:0] STATUS_STOP   = 2'd2;

   // header bytes counted in table_length
   localparam logic [COUNT_BITS-1:0] HEADER_BYTES = 32'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first;
   } req_word_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] offset_out;
      logic [1:0]          status;
   } rsp_word_type;

   typedef struct packed {
      logic                  shift_mode;
      logic                  no_limit;
      logic [COUNT_BITS-1:0] limit;
   } cfg_type;

   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } result_type;

endpackage

// ===== rtl/dotd_csr.sv =====
module dotd_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [dotd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [dotd_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output dotd_pkg::cfg_type                    cfg
);
   import dotd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // limit and no-limit flag are precomputed here, off the decode path
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_SHIFT_MODE: begin
               cfg_in.shift_mode = csr_data[0];
            end
            REG_TABLE_LENGTH: begin
               cfg_in.no_limit = (csr_data < HEADER_BYTES);
               cfg_in.limit    = csr_data - HEADER_BYTES;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.shift_mode <= 1'b0;
         cfg_ff.no_limit   <= 1'b0;
         cfg_ff.limit      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/dotd_input_stage.sv =====
module dotd_input_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dotd_pkg::req_word_type req_word,
   input  logic                  advance,
   output logic                  held_valid,
   output dotd_pkg::req_word_type held_word
);
   import dotd_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;
   logic         take;

   // stall only while a held word cannot move on this cycle
   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign valid_in  = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= req_word;
      end
   end

   assign held_valid = valid_ff;
   assign held_word  = word_ff;

endmodule

// ===== rtl/dotd_decode_core.sv =====
module dotd_decode_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  dotd_pkg::req_word_type word,
   input  dotd_pkg::cfg_type      cfg,
   output dotd_pkg::result_type   result,
   output logic                   stopped
);
   import dotd_pkg::*;

   logic [OFFSET_BITS-1:0] offset_ff,   offset_in;
   logic [COUNT_BITS-1:0]  consumed_ff, consumed_in;
   logic [VALUE_BITS-1:0]  partial_ff,  partial_in;
   logic [1:0]             pending_ff,  pending_in;
   logic                   stopped_ff,  stopped_in;

   logic [OFFSET_BITS-1:0] base_offset;
   logic [COUNT_BITS-1:0]  base_consumed;
   logic [VALUE_BITS-1:0]  base_partial;
   logic [1:0]             base_pending;
   logic                   base_stopped;

   logic [COUNT_BITS-1:0]  count_inc;
   logic [VALUE_BITS-1:0]  shifted_value;
   logic [VALUE_BITS-1:0]  add_value;
   logic [OFFSET_BITS-1:0] offset_sum;
   logic [1:0]             tag;
   logic                   complete;

   function automatic logic [OUT_BITS-1:0] scale(input logic [OFFSET_BITS-1:0] v,
                                                 input logic mode);
      scale = mode ? {v, 3'b000} : {1'b0, v, 2'b00};
   endfunction

   function automatic logic limit_hit(input logic [COUNT_BITS-1:0] n,
                                      input cfg_type c);
      limit_hit = !c.no_limit && (n >= c.limit);
   endfunction

   // first flag restarts the table before the byte is used
   assign base_offset   = word.first ? '0    : offset_ff;
   assign base_consumed = word.first ? '0    : consumed_ff;
   assign base_partial  = word.first ? '0    : partial_ff;
   assign base_pending  = word.first ? 2'd0  : pending_ff;
   assign base_stopped  = word.first ? 1'b0  : stopped_ff;

   // byte count saturates
   assign count_inc = (&base_consumed) ? base_consumed : base_consumed + 1'b1;
   assign shifted_value = {base_partial[VALUE_BITS-9:0], word.data_byte};
   assign tag = word.data_byte[7:6];
   assign offset_sum = base_offset + OFFSET_BITS'(add_value);

   always_comb begin
      offset_in   = base_offset;
      consumed_in = base_consumed;
      partial_in  = base_partial;
      pending_in  = base_pending;
      stopped_in  = base_stopped;
      complete    = 1'b0;
      add_value   = '0;
      result.valid           = 1'b0;
      result.word.status     = STATUS_OFFSET;
      result.word.offset_out = scale(base_offset, cfg.shift_mode);
      if (!base_stopped) begin
         if (base_pending != 2'd0) begin
            partial_in  = shifted_value;
            pending_in  = base_pending - 2'd1;
            consumed_in = count_inc;
            if (base_pending == 2'd1) begin
               complete  = 1'b1;
               add_value = shifted_value;
            end
         end else if (limit_hit(base_consumed, cfg)) begin
            stopped_in = 1'b1;
         end else begin
            consumed_in = count_inc;
            case (tag)
               TAG_STOP: begin
                  stopped_in         = 1'b1;
                  result.valid       = 1'b1;
                  result.word.status = STATUS_STOP;
               end
               TAG_TWO: begin
                  partial_in = VALUE_BITS'(word.data_byte[5:0]);
                  pending_in = 2'd1;
               end
               TAG_FOUR: begin
                  partial_in = VALUE_BITS'(word.data_byte[5:0]);
                  pending_in = 2'd3;
               end
               default: begin
                  // one-byte entry
                  complete  = 1'b1;
                  add_value = VALUE_BITS'(word.data_byte[5:0]);
               end
            endcase
         end
         if (complete) begin
            offset_in              = offset_sum;
            partial_in             = '0;
            result.valid           = 1'b1;
            result.word.offset_out = scale(offset_sum, cfg.shift_mode);
            if (limit_hit(count_inc, cfg)) begin
               stopped_in         = 1'b1;
               result.word.status = STATUS_LIMIT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= '0;
         consumed_ff <= '0;
         partial_ff  <= '0;
         pending_ff  <= 2'd0;
         stopped_ff  <= 1'b1;
      end else if (advance) begin
         offset_ff   <= offset_in;
         consumed_ff <= consumed_in;
         partial_ff  <= partial_in;
         pending_ff  <= pending_in;
         stopped_ff  <= stopped_in;
      end
   end

   assign stopped = stopped_ff;

endmodule

// ===== rtl/dotd_output_stage.sv =====
module dotd_output_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  dotd_pkg::result_type   result,
   output logic                   out_free,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dotd_pkg::rsp_word_type rsp_word
);
   import dotd_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;
   logic         load;

   assign out_free = !valid_ff || !rsp_stall;
   assign load     = advance && result.valid;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= result.word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// ===== rtl/delta_offset_table_decoder.sv =====
// Channel   Ports                         Word
// -------   ---------------------------   ------------------------------
// request   req_valid  req_stall          req_word  (data_byte, first)
// response  rsp_valid  rsp_stall          rsp_word  (offset_out, status)
// config    csr_valid  csr_ready          csr_index, csr_data
//
// One byte per cycle sustained while the response side does not stall; a taken byte waits in
// the input register, and decode runs from the input register into the output (response) register.
// Reset is synchronous, active high; config goes to shift_mode 0, limit 0,
// decoder stopped until a byte with first set.
// A held response stalls the decode stage, which then stalls the request side;
// one byte can still be taken while a response waits.
`include "delta_offset_table_decoder_macros.svh"

module delta_offset_table_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dotd_pkg::req_word_type              req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dotd_pkg::rsp_word_type              rsp_word,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dotd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dotd_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import dotd_pkg::*;

   cfg_type      cfg;
   result_type   result;
   req_word_type held_word;
   logic         held_valid;
   logic         out_free;
   logic         advance;
   logic         stopped;

   // config writes are always accepted and land in the config register
   assign csr_ready = 1'b1;

   // decode step fires when a byte is held and the output register can take
   // whatever it produces
   assign advance = held_valid && out_free;

   dotd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   dotd_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .advance    (advance),
      .held_valid (held_valid),
      .held_word  (held_word)
   );

   dotd_decode_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .word    (held_word),
      .cfg     (cfg),
      .result  (result),
      .stopped (stopped)
   );

   dotd_output_stage u_output (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // request side only stalls behind a held byte
   `DOTD_ASSERT_IMP(a_stall_needs_held, clock, reset,
      req_stall, held_valid, "stall without held byte")

   // a stop or limit result leaves the decoder stopped
   `DOTD_ASSERT_NXT(a_stop_sticks, clock, reset,
      advance && result.valid && (result.word.status != STATUS_OFFSET), stopped,
      "decoder not stopped after final result")

   // a stopped decoder yields nothing until a first byte
   `DOTD_ASSERT_IMP(a_quiet_when_stopped, clock, reset,
      stopped && held_valid && !held_word.first, !result.valid, "result while stopped")

endmodule
